[rtl/core/line_tokenizer_quoted_escapes_unit_assert.svh]
// ----------------------------------------------------------------------------
// Line tokenizer assertion macros
// Shared concurrent assertion forms, clocked on aclk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_TOKENIZER_QUOTED_ESCAPES_UNIT_ASSERT_SVH
`define LINE_TOKENIZER_QUOTED_ESCAPES_UNIT_ASSERT_SVH

// cond must never hold
`define LTQ_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

// ante implies cons in the same cycle
`define LTQ_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define LTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ltq_pkg.sv]
// ----------------------------------------------------------------------------
// Line tokenizer package
// Result types, character and code constants, result builders, hex helpers.
// ----------------------------------------------------------------------------
package ltq_pkg;

    localparam int LINE_LIMIT  = 4096;
    localparam int TOKEN_LIMIT = 1024;

    localparam logic [12:0] LINE_CAP  = 13'((LINE_LIMIT > 8191) ? 8191 : LINE_LIMIT);
    localparam logic [10:0] TOKEN_CAP = 11'((TOKEN_LIMIT > 1024) ? 1024 : TOKEN_LIMIT);

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [1:0] ERR_QUOTE  = 2'd0;
    localparam logic [1:0] ERR_TOKENS = 2'd1;
    localparam logic [1:0] ERR_LONG   = 2'd2;

    localparam logic [1:0] REG_SEP_A     = 2'd0;
    localparam logic [1:0] REG_SEP_B     = 2'd1;
    localparam logic [1:0] REG_MAX_TOK   = 2'd2;
    localparam logic [1:0] REG_MAX_BYTES = 2'd3;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_9         = 8'h39;
    localparam logic [7:0] CH_UA        = 8'h41;
    localparam logic [7:0] CH_UF        = 8'h46;
    localparam logic [7:0] CH_LA        = 8'h61;
    localparam logic [7:0] CH_LF        = 8'h66;

    localparam logic [7:0] DEC_BS  = 8'd8;
    localparam logic [7:0] DEC_FF  = 8'd12;
    localparam logic [7:0] DEC_LF  = 8'd10;
    localparam logic [7:0] DEC_CR  = 8'd13;
    localparam logic [7:0] DEC_TAB = 8'd9;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [9:0]  token_number;
        logic [10:0] token_count;
        logic [1:0]  error_code;
    } ltq_result_t;

    // one to three results caused by one input word
    typedef struct packed {
        logic [1:0]             n;
        ltq_result_t [2:0]      res;
    } ltq_bundle_t;

    function automatic ltq_result_t mk_byte(logic [7:0] c, logic [10:0] tok);
        ltq_result_t r;
        r = '0;
        r.kind         = KIND_BYTE;
        r.data_byte    = c;
        r.token_number = tok[9:0];
        return r;
    endfunction

    function automatic ltq_result_t mk_end(logic [10:0] tok);
        ltq_result_t r;
        r = '0;
        r.kind         = KIND_END;
        r.token_number = tok[9:0];
        return r;
    endfunction

    function automatic ltq_result_t mk_done(logic [10:0] cnt);
        ltq_result_t r;
        r = '0;
        r.kind        = KIND_DONE;
        r.token_count = cnt;
        return r;
    endfunction

    function automatic ltq_result_t mk_err(logic [1:0] code);
        ltq_result_t r;
        r = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    function automatic logic hex_ok(logic [7:0] c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UF)) ||
               ((c >= CH_LA) && (c <= CH_LF));
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] c);
        logic [7:0] v;
        if ((c >= CH_0) && (c <= CH_9)) begin
            v = c - CH_0;
        end else if ((c >= CH_UA) && (c <= CH_UF)) begin
            v = c - CH_UA + 8'd10;
        end else begin
            v = c - CH_LA + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

[rtl/core/ltq_front.sv]
// ----------------------------------------------------------------------------
// Line tokenizer front end
// Holds configuration and parse state, classifies each byte into a bundle.
// ----------------------------------------------------------------------------
module ltq_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_line_byte,
    input  logic                s_end_of_line,
    input  logic                q_full,
    output logic                q_push,
    output ltq_pkg::ltq_bundle_t q_data
);
    import ltq_pkg::*;

    typedef enum logic [2:0] {
        MODE_BETWEEN,
        MODE_PLAIN,
        MODE_QUOTED,
        MODE_ESCAPE,
        MODE_HEX1,
        MODE_HEX2,
        MODE_ENDED,
        MODE_FAILED
    } mode_t;

    logic [7:0]  sep_a_reg;
    logic [7:0]  sep_b_reg;
    logic [10:0] max_tok_reg;
    logic [12:0] max_bytes_reg;

    mode_t       mode_reg, mode_next;
    logic [3:0]  hold_reg, hold_next;
    logic [10:0] tok_reg, tok_next;
    logic [12:0] bytes_reg, bytes_next;

    logic        accept;
    logic [7:0]  c;
    logic        is_sep;
    logic [12:0] line_lim;
    logic [10:0] tok_lim;
    logic [10:0] tok_plus;
    logic [10:0] tok_v_plus;

    ltq_result_t q_res;
    logic        q_has;
    logic        q_inc;
    mode_t       q_mode;

    ltq_result_t p0, p1, e0, e1;
    logic [1:0]  p_n, e_n;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign c        = s_line_byte;
    assign is_sep   = (c == sep_a_reg) || (c == sep_b_reg);
    assign line_lim = (max_bytes_reg < LINE_CAP) ? max_bytes_reg : LINE_CAP;
    assign tok_lim  = (max_tok_reg < TOKEN_CAP) ? max_tok_reg : TOKEN_CAP;
    assign tok_plus = (tok_reg == 11'h7FF) ? tok_reg : tok_reg + 11'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_a_reg     <= 8'd32;
            sep_b_reg     <= 8'd9;
            max_tok_reg   <= 11'd256;
            max_bytes_reg <= 13'd1023;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SEP_A:     sep_a_reg     <= cfg_wdata[7:0];
                REG_SEP_B:     sep_b_reg     <= cfg_wdata[7:0];
                REG_MAX_TOK:   max_tok_reg   <= cfg_wdata[10:0];
                REG_MAX_BYTES: max_bytes_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // byte inside a quoted token
    always_comb begin
        q_has  = 1'b1;
        q_inc  = 1'b0;
        q_mode = MODE_QUOTED;
        q_res  = mk_byte(c, tok_reg);
        if (c == CH_NUL) begin
            q_res  = mk_err(ERR_QUOTE);
            q_mode = MODE_FAILED;
        end else if (c == CH_QUOTE) begin
            q_res  = mk_end(tok_reg);
            q_inc  = 1'b1;
            q_mode = MODE_BETWEEN;
        end else if (c == CH_BACKSLASH) begin
            q_has  = 1'b0;
            q_mode = MODE_ESCAPE;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        hold_next  = hold_reg;
        tok_next   = tok_reg;
        bytes_next = bytes_reg;
        p_n        = 2'd0;
        p0         = q_res;
        p1         = q_res;
        if (mode_reg != MODE_FAILED) begin
            if (bytes_reg != 13'h1FFF) begin
                bytes_next = bytes_reg + 13'd1;
            end
            if (bytes_next >= line_lim) begin
                p_n       = 2'd1;
                p0        = mk_err(ERR_LONG);
                mode_next = MODE_FAILED;
            end else begin
                case (mode_reg)
                    MODE_BETWEEN: begin
                        if (c == CH_NUL) begin
                            mode_next = MODE_ENDED;
                        end else if (is_sep) begin
                            mode_next = MODE_BETWEEN;
                        end else if (tok_reg >= tok_lim) begin
                            p_n       = 2'd1;
                            p0        = mk_err(ERR_TOKENS);
                            mode_next = MODE_FAILED;
                        end else if (c == CH_QUOTE) begin
                            mode_next = MODE_QUOTED;
                        end else begin
                            p_n       = 2'd1;
                            p0        = mk_byte(c, tok_reg);
                            mode_next = MODE_PLAIN;
                        end
                    end
                    MODE_PLAIN: begin
                        p_n = 2'd1;
                        if (c == CH_NUL || is_sep) begin
                            p0        = mk_end(tok_reg);
                            tok_next  = tok_plus;
                            mode_next = (c == CH_NUL) ? MODE_ENDED : MODE_BETWEEN;
                        end else begin
                            p0 = mk_byte(c, tok_reg);
                        end
                    end
                    MODE_QUOTED: begin
                        p_n       = {1'b0, q_has};
                        p0        = q_res;
                        mode_next = q_mode;
                        if (q_inc) begin
                            tok_next = tok_plus;
                        end
                    end
                    MODE_ESCAPE: begin
                        mode_next = MODE_QUOTED;
                        p_n       = 2'd1;
                        case (c)
                            CH_NUL: begin
                                p0        = mk_err(ERR_QUOTE);
                                mode_next = MODE_FAILED;
                            end
                            CH_B:  p0 = mk_byte(DEC_BS, tok_reg);
                            CH_F:  p0 = mk_byte(DEC_FF, tok_reg);
                            CH_N:  p0 = mk_byte(DEC_LF, tok_reg);
                            CH_R:  p0 = mk_byte(DEC_CR, tok_reg);
                            CH_T:  p0 = mk_byte(DEC_TAB, tok_reg);
                            CH_X: begin
                                p_n       = 2'd0;
                                mode_next = MODE_HEX1;
                                hold_next = 4'd0;
                            end
                            CH_NL: p_n = 2'd0;
                            default: p0 = mk_byte(c, tok_reg);
                        endcase
                    end
                    MODE_HEX1: begin
                        if (hex_ok(c)) begin
                            hold_next = hex_val(c);
                            mode_next = MODE_HEX2;
                        end else begin
                            p0        = mk_byte(8'd0, tok_reg);
                            p1        = q_res;
                            p_n       = q_has ? 2'd2 : 2'd1;
                            mode_next = q_mode;
                            if (q_inc) begin
                                tok_next = tok_plus;
                            end
                        end
                    end
                    MODE_HEX2: begin
                        hold_next = 4'd0;
                        mode_next = MODE_QUOTED;
                        if (hex_ok(c)) begin
                            p_n = 2'd1;
                            p0  = mk_byte({hold_reg, hex_val(c)}, tok_reg);
                        end else begin
                            p0        = mk_byte({4'd0, hold_reg}, tok_reg);
                            p1        = q_res;
                            p_n       = q_has ? 2'd2 : 2'd1;
                            mode_next = q_mode;
                            if (q_inc) begin
                                tok_next = tok_plus;
                            end
                        end
                    end
                    default: mode_next = mode_reg;
                endcase
            end
        end
    end

    assign tok_v_plus = (tok_next == 11'h7FF) ? tok_next : tok_next + 11'd1;

    // end of line closes the line
    always_comb begin
        e_n = 2'd0;
        e0  = mk_done(tok_next);
        e1  = mk_done(tok_v_plus);
        if (s_end_of_line) begin
            case (mode_next)
                MODE_FAILED: e_n = 2'd0;
                MODE_PLAIN: begin
                    e0  = mk_end(tok_next);
                    e_n = 2'd2;
                end
                MODE_QUOTED, MODE_ESCAPE, MODE_HEX1, MODE_HEX2: begin
                    e0  = mk_err(ERR_QUOTE);
                    e_n = 2'd1;
                end
                default: e_n = 2'd1;
            endcase
        end
    end

    always_comb begin
        q_data        = '0;
        q_data.n      = p_n + e_n;
        q_data.res[0] = (p_n != 2'd0) ? p0 : e0;
        case (p_n)
            2'd0:    q_data.res[1] = e1;
            2'd1:    q_data.res[1] = e0;
            default: q_data.res[1] = p1;
        endcase
        q_data.res[2] = (p_n == 2'd2) ? e0 : e1;
    end

    assign q_push = accept && (q_data.n != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_BETWEEN;
            hold_reg  <= 4'd0;
            tok_reg   <= 11'd0;
            bytes_reg <= 13'd0;
        end else if (accept) begin
            if (s_end_of_line) begin
                mode_reg  <= MODE_BETWEEN;
                hold_reg  <= 4'd0;
                tok_reg   <= 11'd0;
                bytes_reg <= 13'd0;
            end else begin
                mode_reg  <= mode_next;
                hold_reg  <= hold_next;
                tok_reg   <= tok_next;
                bytes_reg <= bytes_next;
            end
        end
    end

endmodule

[rtl/core/ltq_fifo.sv]
// ----------------------------------------------------------------------------
// Line tokenizer bundle queue
// Short register queue between front end and result serializer.
// ----------------------------------------------------------------------------
`include "line_tokenizer_quoted_escapes_unit_assert.svh"

module ltq_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ltq_pkg::ltq_bundle_t push_data,
    output logic                full,
    input  logic                pop,
    output ltq_pkg::ltq_bundle_t head,
    output logic                empty
);
    import ltq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ltq_bundle_t     mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `LTQ_ASSERT_NEVER(a_no_overflow, push && full, "push into full queue")
    `LTQ_ASSERT_NEVER(a_no_underflow, pop && empty, "pop from empty queue")
    `LTQ_ASSERT_NEVER(a_count_range, count_reg > CW'(DEPTH), "queue count out of range")
    `LTQ_ASSERT_NEXT(a_push_fills, push && !pop, !empty, "queue empty after push")

endmodule

[rtl/core/ltq_back.sv]
// ----------------------------------------------------------------------------
// Line tokenizer result serializer
// Sends bundle results via an output register, one word per cycle while m_ready.
// ----------------------------------------------------------------------------
module ltq_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  ltq_pkg::ltq_bundle_t head,
    input  logic                empty,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic [7:0]          m_data_byte,
    output logic [9:0]          m_token_number,
    output logic [10:0]         m_token_count,
    output logic [1:0]          m_error_code,
    output logic                m_last_of_run
);
    import ltq_pkg::*;

    logic        valid_reg;
    logic [1:0]  idx_reg;
    ltq_result_t out_reg;
    logic        last_reg;

    logic        load;
    logic        is_last;
    ltq_result_t pick;

    assign load    = !empty && (!valid_reg || m_ready);
    assign is_last = (idx_reg == (head.n - 2'd1));
    assign pop     = load && is_last;

    always_comb begin
        case (idx_reg)
            2'd0:    pick = head.res[0];
            2'd1:    pick = head.res[1];
            default: pick = head.res[2];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= is_last ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg  <= pick;
            last_reg <= is_last;
        end
    end

    assign m_valid        = valid_reg;
    assign m_kind         = out_reg.kind;
    assign m_data_byte    = out_reg.data_byte;
    assign m_token_number = out_reg.token_number;
    assign m_token_count  = out_reg.token_count;
    assign m_error_code   = out_reg.error_code;
    assign m_last_of_run  = last_reg;

endmodule

[rtl/core/line_tokenizer_quoted_escapes_unit.sv]
// ----------------------------------------------------------------------------
// Line tokenizer with quoted strings and escapes
// Splits lines into tokens, decodes quoted escapes, reports counts and errors.
// ----------------------------------------------------------------------------
// Usage:
//   Line bytes enter on the s_ channel, one byte per word, with s_end_of_line
//   on the last byte of a line. Results leave on the m_ channel: token bytes,
//   token ends, a line-done count or one error, m_last_of_run marking the
//   final result of each input byte.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while the
//   block is idle; writes take effect on the next byte.
//   A byte's first result passes through the bundle queue and then the output
//   register. Throughput: one byte per cycle while the queue is not full; a
//   byte with up to three results holds the result serializer until each is
//   sent, absorbed by the bundle queue of QUEUE_DEPTH entries in front of it.
//   Reset loads the register defaults and starts between tokens on a new line.
//   When the receiver stalls, the output register holds its word, the queue
//   fills, and s_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module line_tokenizer_quoted_escapes_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_line_byte,
    input  logic        s_end_of_line,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_data_byte,
    output logic [9:0]  m_token_number,
    output logic [10:0] m_token_count,
    output logic [1:0]  m_error_code,
    output logic        m_last_of_run
);
    import ltq_pkg::*;

    ltq_bundle_t push_data;
    ltq_bundle_t head;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;

    ltq_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_line_byte   (s_line_byte),
        .s_end_of_line (s_end_of_line),
        .q_full        (full),
        .q_push        (push),
        .q_data        (push_data)
    );

    ltq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    ltq_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_data_byte    (m_data_byte),
        .m_token_number (m_token_number),
        .m_token_count  (m_token_count),
        .m_error_code   (m_error_code),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

[bench/tb_line_tokenizer_quoted_escapes_unit.sv]
// ----------------------------------------------------------------------------
// Line tokenizer testbench
// Feeds byte streams of text lines into the tokenizer and predicts every result
// word in a local parser model. The words are then matched in order. A short
// hand-built table runs first. Random lines follow under five register
// settings and several idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_line_tokenizer_quoted_escapes_unit;

    import ltq_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_WORDS   = 32;
    localparam int REPORT_LIMIT   = 100;
    localparam int NUM_PHASES     = 5;

    localparam logic [7:0]  PH_SEP_A [NUM_PHASES] = '{8'h20, 8'h2C, 8'h00, 8'h20, 8'h20};
    localparam logic [7:0]  PH_SEP_B [NUM_PHASES] = '{8'h09, 8'h22, 8'hFF, 8'h3B, 8'h09};
    localparam logic [10:0] PH_TOK   [NUM_PHASES] = '{11'd256, 11'd1, 11'd1024, 11'd3, 11'd256};
    localparam logic [12:0] PH_LEN   [NUM_PHASES] = '{13'd1023, 13'd4096, 13'd1, 13'd12,
                                                      13'd3000};
    localparam int PH_SRC_IDLE  [NUM_PHASES] = '{0, 73, 0, 25, 0};
    localparam int PH_RCV_STALL [NUM_PHASES] = '{0, 0, 73, 25, 0};
    localparam logic [1:0] REG_ORDER [4] = '{REG_SEP_A, REG_SEP_B, REG_MAX_TOK, REG_MAX_BYTES};

    typedef enum logic [2:0] {
        PS_GAP, PS_PLAIN, PS_QUOTED, PS_ESCAPE, PS_HEX_HI, PS_HEX_LO, PS_ENDED, PS_FAILED
    } parse_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [9:0]  token_number;
        logic [10:0] token_count;
        logic [1:0]  error_code;
        logic        last_of_run;
    } result_word_t;

    typedef struct packed {
        logic [7:0]   line_byte;
        logic         end_of_line;
        logic         pinned;
        result_word_t want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_line_byte;
    logic        s_end_of_line;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_data_byte;
    logic [9:0]  m_token_number;
    logic [10:0] m_token_count;
    logic [1:0]  m_error_code;
    logic        m_last_of_run;

    // parser model state and register copy
    parse_state_t pstate;
    logic [3:0]   hex_hold;
    logic [10:0]  tokens_seen;
    logic [12:0]  bytes_seen;
    logic [7:0]   sep_a;
    logic [7:0]   sep_b;
    logic [10:0]  tok_max;
    logic [12:0]  line_max;

    result_word_t step_words [$];
    result_word_t expected_words [$];
    stim_row_t    directed_rows [$];

    int src_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int failures      = 0;
    int reports       = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int lines_closed  = 0;
    int quiet_cycles  = 0;

    line_tokenizer_quoted_escapes_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_line_byte    (s_line_byte),
        .s_end_of_line  (s_end_of_line),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_data_byte    (m_data_byte),
        .m_token_number (m_token_number),
        .m_token_count  (m_token_count),
        .m_error_code   (m_error_code),
        .m_last_of_run  (m_last_of_run)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    function automatic void add_word(logic [1:0] k, logic [7:0] d, logic [9:0] n,
                                     logic [10:0] cnt, logic [1:0] code);
        result_word_t w;
        w.kind         = k;
        w.data_byte    = d;
        w.token_number = n;
        w.token_count  = cnt;
        w.error_code   = code;
        w.last_of_run  = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void token_char(logic [7:0] c);
        add_word(KIND_BYTE, c, tokens_seen[9:0], '0, '0);
    endfunction

    function automatic void raise_error(logic [1:0] code);
        add_word(KIND_ERROR, '0, '0, '0, code);
        pstate = PS_FAILED;
    endfunction

    function automatic void close_token();
        add_word(KIND_END, '0, tokens_seen[9:0], '0, '0);
        if (tokens_seen != 11'h7FF) begin
            tokens_seen++;
        end
    endfunction

    function automatic void start_line();
        pstate      = PS_GAP;
        hex_hold    = '0;
        tokens_seen = '0;
        bytes_seen  = '0;
    endfunction

    function automatic int nibble_of(logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        return -1;
    endfunction

    function automatic void quoted_char(logic [7:0] c);
        if (c == CH_NUL) begin
            raise_error(ERR_QUOTE);
        end else if (c == CH_QUOTE) begin
            close_token();
            pstate = PS_GAP;
        end else if (c == CH_BACKSLASH) begin
            pstate = PS_ESCAPE;
        end else begin
            token_char(c);
        end
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        int          h;
        logic [10:0] tok_cap;
        tok_cap = (tok_max > TOKEN_CAP) ? TOKEN_CAP : tok_max;
        case (pstate)
            PS_GAP: begin
                if (c == CH_NUL) begin
                    pstate = PS_ENDED;
                end else if (c != sep_a && c != sep_b) begin
                    if (tokens_seen >= tok_cap) begin
                        raise_error(ERR_TOKENS);
                    end else if (c == CH_QUOTE) begin
                        pstate = PS_QUOTED;
                    end else begin
                        token_char(c);
                        pstate = PS_PLAIN;
                    end
                end
            end
            PS_PLAIN: begin
                if (c == CH_NUL) begin
                    close_token();
                    pstate = PS_ENDED;
                end else if (c == sep_a || c == sep_b) begin
                    close_token();
                    pstate = PS_GAP;
                end else begin
                    token_char(c);
                end
            end
            PS_QUOTED: quoted_char(c);
            PS_ESCAPE: begin
                pstate = PS_QUOTED;
                case (c)
                    CH_NUL: raise_error(ERR_QUOTE);
                    CH_B:   token_char(DEC_BS);
                    CH_F:   token_char(DEC_FF);
                    CH_N:   token_char(DEC_LF);
                    CH_R:   token_char(DEC_CR);
                    CH_T:   token_char(DEC_TAB);
                    CH_X: begin
                        pstate   = PS_HEX_HI;
                        hex_hold = '0;
                    end
                    CH_NL:  ;
                    default: token_char(c);
                endcase
            end
            PS_HEX_HI: begin
                h = nibble_of(c);
                if (h >= 0) begin
                    hex_hold = h[3:0];
                    pstate   = PS_HEX_LO;
                end else begin
                    token_char(8'h00);
                    pstate = PS_QUOTED;
                    quoted_char(c);
                end
            end
            PS_HEX_LO: begin
                h      = nibble_of(c);
                pstate = PS_QUOTED;
                if (h >= 0) begin
                    token_char({hex_hold, h[3:0]});
                end else begin
                    token_char({4'h0, hex_hold});
                    quoted_char(c);
                end
                hex_hold = '0;
            end
            default: ;
        endcase
    endfunction

    // fills step_words with the words caused by one byte
    function automatic void predict_word(logic [7:0] c, logic eol);
        logic [12:0]  line_cap;
        result_word_t w;
        step_words.delete();
        line_cap = (line_max > LINE_CAP) ? LINE_CAP : line_max;
        if (pstate != PS_FAILED) begin
            if (bytes_seen != 13'h1FFF) begin
                bytes_seen++;
            end
            if (bytes_seen >= line_cap) begin
                raise_error(ERR_LONG);
            end else begin
                scan_byte(c);
            end
        end
        if (eol) begin
            case (pstate)
                PS_FAILED: ;
                PS_PLAIN: begin
                    close_token();
                    add_word(KIND_DONE, '0, '0, tokens_seen, '0);
                end
                PS_QUOTED, PS_ESCAPE, PS_HEX_HI, PS_HEX_LO: raise_error(ERR_QUOTE);
                default: add_word(KIND_DONE, '0, '0, tokens_seen, '0);
            endcase
            start_line();
        end
        if (step_words.size() > 0) begin
            w = step_words.pop_back();
            w.last_of_run = 1'b1;
            step_words.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic void add_row(logic [7:0] c, logic eol, logic pin = 1'b0,
                                    logic [1:0] k = KIND_BYTE, logic [7:0] d = '0,
                                    logic [9:0] n = '0, logic [10:0] cnt = '0,
                                    logic [1:0] code = '0);
        stim_row_t r;
        r.line_byte   = c;
        r.end_of_line = eol;
        r.pinned      = pin;
        r.want        = {k, d, n, cnt, code, 1'b1};
        directed_rows.push_back(r);
    endfunction

    function automatic logic [7:0] pick_sep();
        return ($urandom_range(1) != 0) ? sep_a : sep_b;
    endfunction

    function automatic logic [7:0] pick_byte(bit in_quotes);
        logic [7:0] c;
        do begin
            c = ($urandom_range(3) != 0) ? 8'($urandom_range(8'h21, 8'h7E))
                                         : 8'($urandom_range(1, 255));
        end while (in_quotes ? (c == CH_QUOTE || c == CH_BACKSLASH)
                             : (c == sep_a || c == sep_b));
        return c;
    endfunction

    task automatic push_word(input logic [7:0] c, input logic eol, input logic pin,
                             input result_word_t want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_line_byte   <= c;
        s_end_of_line <= eol;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_word(c, eol);
        words_sent++;
        if (pin) begin
            expected_words.push_back(want);
        end else begin
            foreach (step_words[i]) expected_words.push_back(step_words[i]);
        end
        @(negedge aclk);
    endtask

    task automatic send_line();
        logic [7:0] text [$];
        int         ntok;
        logic [3:0] v;
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(255)));
        end else begin
            if ($urandom_range(3) == 0) begin
                text.push_back(pick_sep());
            end
            ntok = $urandom_range(0, 4);
            for (int t = 0; t < ntok; t++) begin
                if (t > 0) begin
                    repeat ($urandom_range(1, 2)) text.push_back(pick_sep());
                end
                if ($urandom_range(1) == 0) begin
                    repeat ($urandom_range(1, 4)) text.push_back(pick_byte(1'b0));
                end else begin
                    text.push_back(CH_QUOTE);
                    repeat ($urandom_range(0, 4)) begin
                        case ($urandom_range(3))
                            0: text.push_back(pick_byte(1'b1));
                            1: begin
                                text.push_back(CH_BACKSLASH);
                                case ($urandom_range(8))
                                    0: text.push_back(CH_B);
                                    1: text.push_back(CH_F);
                                    2: text.push_back(CH_N);
                                    3: text.push_back(CH_R);
                                    4: text.push_back(CH_T);
                                    5: text.push_back(CH_QUOTE);
                                    6: text.push_back(CH_BACKSLASH);
                                    7: text.push_back(CH_NL);
                                    default: text.push_back(8'($urandom_range(1, 255)));
                                endcase
                            end
                            2: begin
                                text.push_back(CH_BACKSLASH);
                                text.push_back(CH_X);
                                repeat ($urandom_range(0, 2)) begin
                                    v = 4'($urandom_range(15));
                                    if (v < 4'd10) begin
                                        text.push_back(CH_0 + 8'(v));
                                    end else begin
                                        text.push_back((($urandom_range(1) != 0) ? CH_UA : CH_LA)
                                                       + 8'(v) - 8'd10);
                                    end
                                end
                            end
                            default: repeat (2) text.push_back(pick_byte(1'b1));
                        endcase
                    end
                    // now and then leave the quote open
                    if ($urandom_range(11) != 0) begin
                        text.push_back(CH_QUOTE);
                    end
                end
            end
            if ($urandom_range(3) == 0) begin
                text.push_back(pick_sep());
            end
            if ($urandom_range(9) == 0) begin
                text.insert($urandom_range(text.size()), CH_NUL);
            end
        end
        if (text.size() == 0) begin
            text.push_back(pick_sep());
        end
        foreach (text[i]) push_word(text[i], (i == text.size() - 1), 1'b0, '0);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic load_settings(input logic [7:0] a, input logic [7:0] b,
                                 input logic [10:0] tok, input logic [12:0] len);
        logic [12:0] vals [4];
        vals[0] = {5'd0, a};
        vals[1] = {5'd0, b};
        vals[2] = {2'd0, tok};
        vals[3] = len;
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_wdata <= vals[i];
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
        sep_a    = a;
        sep_b    = b;
        tok_max  = tok;
        line_max = len;
    endtask

    // ------------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------------
    function automatic bit field_ok(string name, logic [10:0] want_v, logic [10:0] got_v);
        if (got_v === want_v) return 1'b1;
        if (reports < REPORT_LIMIT) begin
            reports++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
        end
        return 1'b0;
    endfunction

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    always @(posedge aclk) begin
        result_word_t seen;
        result_word_t want;
        bit           ok;
        if (aresetn && m_valid && m_ready) begin
            seen = {m_kind, m_data_byte, m_token_number, m_token_count, m_error_code,
                    m_last_of_run};
            words_checked++;
            if (seen.kind == KIND_DONE || seen.kind == KIND_ERROR) begin
                lines_closed++;
            end
            if (expected_words.size() == 0) begin
                failures++;
                $display("%0t: expected no word, got kind %0d data %0h token %0d count %0d",
                         $time, seen.kind, seen.data_byte, seen.token_number,
                         seen.token_count);
            end else begin
                want = expected_words.pop_front();
                ok = field_ok("kind", 11'(want.kind), 11'(seen.kind))
                   & field_ok("data_byte", 11'(want.data_byte), 11'(seen.data_byte))
                   & field_ok("token_number", 11'(want.token_number), 11'(seen.token_number))
                   & field_ok("token_count", want.token_count, seen.token_count)
                   & field_ok("error_code", 11'(want.error_code), 11'(seen.error_code))
                   & field_ok("last_of_run", 11'(want.last_of_run), 11'(seen.last_of_run));
                if (!ok) begin
                    failures++;
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int start_count;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_line_byte   = '0;
        s_end_of_line = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_SEP_A;
        cfg_wdata     = '0;
        sep_a         = 8'd32;
        sep_b         = 8'd9;
        tok_max       = 11'd256;
        line_max      = 13'd1023;
        start_line();

        //      byte   eol   pin   kind        data   tok    count  code
        add_row(8'h61, 1'b0, 1'b1, KIND_BYTE,  8'h61, 10'd0);
        add_row(8'hFF, 1'b0, 1'b1, KIND_BYTE,  8'hFF, 10'd0);
        add_row(8'h20, 1'b0, 1'b1, KIND_END,   8'h00, 10'd0);
        add_row(8'h09, 1'b0);
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_BACKSLASH, 1'b0);
        add_row(CH_N, 1'b0);
        add_row(CH_BACKSLASH, 1'b0);
        add_row(CH_X, 1'b0);
        add_row(8'h34, 1'b0);
        add_row(8'h31, 1'b0);
        add_row(CH_BACKSLASH, 1'b0);
        add_row(CH_X, 1'b0);
        add_row(8'h67, 1'b0);
        add_row(CH_BACKSLASH, 1'b0);
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_BACKSLASH, 1'b0);
        add_row(CH_NL, 1'b0);
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_NUL, 1'b0);
        add_row(8'h7A, 1'b1, 1'b1, KIND_DONE,  8'h00, 10'd0, 11'd2);
        add_row(CH_QUOTE, 1'b0);
        add_row(CH_BACKSLASH, 1'b0);
        add_row(CH_X, 1'b0);
        add_row(CH_UA, 1'b1, 1'b1, KIND_ERROR, 8'h00, 10'd0, 11'd0, ERR_QUOTE);

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            push_word(directed_rows[i].line_byte, directed_rows[i].end_of_line,
                      directed_rows[i].pinned, directed_rows[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                wait_idle();
                load_settings(PH_SEP_A[p], PH_SEP_B[p], PH_TOK[p], PH_LEN[p]);
            end
            src_idle_pct  = PH_SRC_IDLE[p];
            rcv_stall_pct = PH_RCV_STALL[p];
            start_count   = words_sent;
            while (words_sent - start_count < RANDOM_WORDS) send_line();
        end
        wait_idle();

        $display("Sent %0d line bytes under %0d register settings (separators 00/FF, 1 to 1024",
                 words_sent, NUM_PHASES);
        $display("tokens, 1 to 4096 bytes); checked %0d result words, %0d lines closed.",
                 words_checked, lines_closed);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
